// ----- rtl/cpr_pkg.sv -----
// Shared widths and constants for the prime counter.
package cpr_pkg;

  localparam int FIELD_WIDTH = 16;
  localparam int VALUE_WIDTH = 16;
  localparam int COUNT_WIDTH = 17;
  localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH + 1);

  typedef logic [FIELD_WIDTH-1:0] field_t;
  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [VALUE_WIDTH:0]   square_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [STEP_WIDTH-1:0]  step_t;

  localparam value_t PRIME_MIN = value_t'(2);
  localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

endpackage

// ----- rtl/cpr_rem_unit.sv -----
// Restoring remainder unit: one quotient bit per cycle.
module cpr_rem_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  cpr_pkg::value_t dividend,
  input  cpr_pkg::value_t divisor,
  output logic            done,
  output cpr_pkg::value_t remainder
);
  import cpr_pkg::*;

  logic   busy;
  step_t  steps;
  value_t shreg;
  value_t dvs;
  value_t rem;

  logic [VALUE_WIDTH:0] trial;
  logic                 fits;

  assign trial = {rem, shreg[VALUE_WIDTH-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= step_t'(VALUE_WIDTH);
        shreg <= dividend;
        dvs   <= divisor;
        rem   <= '0;
      end else if (busy) begin
        shreg <= {shreg[VALUE_WIDTH-2:0], 1'b0};
        steps <= steps - step_t'(1);
        if (fits) begin
          rem <= value_t'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[VALUE_WIDTH-1:0];
        end
        if (steps == step_t'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem;

endmodule

// ----- rtl/count_primes_in_range.sv -----
// Prime counter over an inclusive range, trial division with a shared remainder unit.
//
//   channel | beat fields              | handshake
//   --------+--------------------------+----------------------
//   in      | range_start, range_stop  | in_valid / in_ready
//   out     | prime_count              | out_valid / out_ready
//
// Steps: a trial divisor is a start in TRIAL, the remainder steps, a check in WAIT; a
//   number also passes TEST and ADVANCE, and TRIAL again when prime; a range adds the
//   accept and FINISH. The remainder unit, the only arithmetic loop, sets the total.
// Reset: rst (synchronous) returns the sequencer to idle and drops out_valid.
// Stalls: a result waits in the output register; the next range is taken
//   while it waits, and a finished count waits only if the register is full.
module count_primes_in_range (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cpr_pkg::field_t range_start,
  input  cpr_pkg::field_t range_stop,
  output logic            out_valid,
  input  logic            out_ready,
  output cpr_pkg::count_t prime_count
);
  import cpr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_TRIAL,
    ST_WAIT,
    ST_ADVANCE,
    ST_FINISH
  } state_t;

  state_t  state;
  value_t  candidate;
  value_t  last;
  value_t  trial_divisor;
  square_t divisor_sq;
  count_t  running_count;

  logic    rem_start;
  logic    rem_done;
  value_t  partial_remainder;

  assign in_ready  = (state == ST_IDLE);
  assign rem_start = (state == ST_TRIAL) && (divisor_sq <= {1'b0, candidate});

  cpr_rem_unit u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (candidate),
    .divisor   (trial_divisor),
    .done      (rem_done),
    .remainder (partial_remainder)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // in FINISH the output register is reloaded below
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            candidate     <= value_t'(range_start);
            last          <= value_t'(range_stop);
            running_count <= '0;
            if (value_t'(range_start) > value_t'(range_stop)) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_TEST;
            end
          end
        end
        ST_TEST: begin
          if (candidate < PRIME_MIN) begin
            state <= ST_ADVANCE;
          end else begin
            trial_divisor <= PRIME_MIN;
            divisor_sq    <= square_t'(4);
            state         <= ST_TRIAL;
          end
        end
        ST_TRIAL: begin
          if (rem_start) begin
            state <= ST_WAIT;
          end else begin
            // no divisor up to the root: prime
            if (running_count != COUNT_MAX) begin
              running_count <= running_count + count_t'(1);
            end
            state <= ST_ADVANCE;
          end
        end
        ST_WAIT: begin
          if (rem_done) begin
            if (partial_remainder == '0) begin
              state <= ST_ADVANCE;
            end else begin
              // (d+1)^2 = d^2 + 2d + 1
              divisor_sq    <= divisor_sq + {trial_divisor, 1'b1};
              trial_divisor <= trial_divisor + value_t'(1);
              state         <= ST_TRIAL;
            end
          end
        end
        ST_ADVANCE: begin
          if (candidate == last) begin
            state <= ST_FINISH;
          end else begin
            candidate <= candidate + value_t'(1);
            state     <= ST_TEST;
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            prime_count <= running_count;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != ST_IDLE)
    else $error("accepted beat did not start a walk");

  a_done_only_waiting: assert property (@(posedge clk) disable iff (rst)
    rem_done |-> state == ST_WAIT)
    else $error("remainder done outside wait");

  a_divisor_min: assert property (@(posedge clk) disable iff (rst)
    rem_start |-> trial_divisor >= PRIME_MIN && candidate >= PRIME_MIN)
    else $error("trial division with bad operands");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && (!out_valid || out_ready) |=> out_valid && state == ST_IDLE)
    else $error("finished count not loaded");

endmodule

// ----- sim/count_primes_in_range_tb.sv -----
// Testbench for count_primes_in_range: random handshakes, scoreboard of predicted counts.
module count_primes_in_range_tb;
  import cpr_pkg::*;

  // Predicted prime counts, in beat order, plus a running estimate of the
  // cycles the block may need, which feeds the watchdog.
  class prime_tally;
    count_t          counts_due[$];
    int              errors;
    longint unsigned work_estimate;

    // Trial division over [lo, hi]; trials returns the number of divisions done.
    function count_t primes_between(field_t lo_f, field_t hi_f,
                                    output longint unsigned trials);
      value_t      lo;
      value_t      hi;
      int unsigned n;
      int unsigned d;
      count_t      total;
      bit          composite;
      lo     = value_t'(lo_f);
      hi     = value_t'(hi_f);
      total  = '0;
      trials = 0;
      if (lo <= hi) begin
        for (n = lo; n <= hi; n++) begin
          if (n >= PRIME_MIN) begin
            composite = 1'b0;
            for (d = PRIME_MIN; d * d <= n && !composite; d++) begin
              trials++;
              if (n % d == 0) composite = 1'b1;
            end
            // saturate, as a wider value field could overflow the count
            if (!composite && total != COUNT_MAX) total++;
          end
        end
      end
      return total;
    endfunction

    // Called once per accepted input beat.
    function void take_range(field_t lo, field_t hi);
      longint unsigned trials;
      longint unsigned span;
      count_t          want;
      want = primes_between(lo, hi, trials);
      span = (value_t'(lo) <= value_t'(hi)) ? value_t'(hi) - value_t'(lo) + 1 : 0;
      counts_due.push_back(want);
      // a term per divisor trial, a term per number in the span, and slack for stalls
      work_estimate += trials * (VALUE_WIDTH + 2) + 4 * span + 400;
    endfunction

    // Called once per accepted output beat.
    function void check_count(count_t seen);
      count_t want;
      if (counts_due.size() == 0) begin
        $display("%0t: unexpected result beat, prime_count %0d", $time, seen);
        errors++;
      end else begin
        want = counts_due.pop_front();
        if (want !== seen) begin
          $display("%0t: prime_count mismatch, expected %0d, actual %0d",
                   $time, want, seen);
          errors++;
        end
      end
    endfunction

    function int pending();
      return counts_due.size();
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  field_t range_start = '0;
  field_t range_stop = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  count_t prime_count;

  prime_tally tally = new;

  count_primes_in_range dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .range_start (range_start),
    .range_stop  (range_stop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .prime_count (prime_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Idle cycles before an input beat: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One input beat. Valid stays high across back-to-back beats.
  task automatic send_range(input field_t lo, input field_t hi);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    range_start <= lo;
    range_stop  <= hi;
    do @(posedge clk); while (!in_ready);
    tally.take_range(lo, hi);
  endtask

  // Let every predicted count drain before going on.
  task automatic drain_results();
    while (tally.pending() != 0) @(posedge clk);
  endtask

  // Random range: mostly short spans anywhere, some wide spans low down
  // (cheap to walk), some empty ranges and single numbers.
  task automatic send_random_range();
    int          roll;
    int unsigned lo;
    int unsigned hi;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      lo = $urandom_range(0, 65535);
      hi = lo + $urandom_range(0, 20);
      if (hi > 65535) hi = 65535;
    end else if (roll < 80) begin
      lo = $urandom_range(0, 400);
      hi = lo + $urandom_range(0, 200);
    end else if (roll < 90) begin
      lo = $urandom_range(1, 65535);
      hi = $urandom_range(0, lo - 1);
    end else begin
      lo = $urandom_range(0, 65535);
      hi = lo;
    end
    send_range(field_t'(lo), field_t'(hi));
  endtask

  // Result side: random runs of ready high and ready low.
  initial begin : result_sink
    int roll;
    int run;
    logic ready_level;
    while (rst) @(posedge clk);
    forever begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        ready_level = 1'b1;
        run = $urandom_range(1, 20);
      end else begin
        ready_level = 1'b0;
        if (roll < 85) run = $urandom_range(1, 3);
        else if (roll < 97) run = $urandom_range(4, 15);
        else run = $urandom_range(30, 60);
      end
      out_ready <= ready_level;
      repeat (run) begin
        @(posedge clk);
        if (out_valid && out_ready) tally.check_count(prime_count);
      end
    end
  end

  // Watchdog: the limit follows the predicted work, several times over.
  initial begin : watchdog
    longint unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count <= 4 * tally.work_estimate + 50000) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : run_control
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: below two, smallest primes, field extremes
    send_range(16'd0, 16'd0);
    send_range(16'd1, 16'd1);
    send_range(16'd2, 16'd2);
    send_range(16'd3, 16'd3);
    send_range(16'd4, 16'd4);
    send_range(16'd2, 16'd3);
    send_range(16'd0, 16'd10);
    send_range(16'hFFFF, 16'hFFFF);
    send_range(16'd65521, 16'd65521);   // largest 16-bit prime, longest divisor walk
    send_range(16'd63001, 16'd63001);   // square of a prime, last divisor hits
    send_range(16'd49, 16'd49);
    send_range(16'd7919, 16'd7919);
    // empty ranges
    send_range(16'hFFFF, 16'h0000);
    send_range(16'd1, 16'd0);
    send_range(16'hFFFF, 16'hFFFE);
    send_range(16'h00FF, 16'h00FE);
    // spans over the top of the field, the low end and alternating bit patterns
    send_range(16'd65500, 16'hFFFF);
    send_range(16'd0, 16'd300);
    send_range(16'h8000, 16'h8010);
    send_range(16'h5555, 16'h5560);
    send_range(16'hAAAA, 16'hAAB0);
    send_range(16'h7FF0, 16'h7FFF);

    // hold the sender until the block has handed back everything
    in_valid <= 1'b0;
    drain_results();

    for (int i = 0; i < 78; i++) begin
      if (i == 40) begin
        in_valid <= 1'b0;
        drain_results();
      end
      send_random_range();
    end
    in_valid <= 1'b0;

    drain_results();
    repeat (200) @(posedge clk);
    if (tally.pending() != 0) begin
      $display("%0t: %0d predicted counts never arrived", $time, tally.pending());
      tally.errors++;
    end
    if (tally.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
